// ===== hdl/pfc_pkg.sv =====
// Shared types and constants for the packet flow classifier.
package pfc_pkg;

    localparam logic [15:0] ETHTYPE_V4    = 16'h0800;
    localparam logic [15:0] ETHTYPE_V6    = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [3:0]  VER_4         = 4'd4;
    localparam logic [3:0]  VER_6         = 4'd6;
    localparam logic [17:0] ETH_HDR_BYTES = 18'd14;
    localparam logic [17:0] V6_HDR_BYTES  = 18'd40;
    localparam logic [5:0]  UDP_HDR_BYTES = 6'd8;

    localparam logic [1:0] CLASS_DROP = 2'd0;
    localparam logic [1:0] CLASS_TCP  = 2'd1;
    localparam logic [1:0] CLASS_UDP  = 2'd2;

    localparam int IN_BITS  = 352;
    localparam int OUT_BITS = 250;
    localparam int KEY_BITS = 290;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_INSERT,
        ST_COUNT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic cnt_step;
        logic insert;
        logic count;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic match;
        logic scan_end;
    } status_t;

endpackage

// ===== hdl/pfc_ctrl.sv =====
// Sequencer for the flow table scan.
module pfc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  pfc_pkg::status_t st,
    output pfc_pkg::cmd_t    cmd
);

    pfc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pfc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            pfc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = pfc_pkg::ST_READ;
                end
            end
            pfc_pkg::ST_READ:
            begin
                // drop and end-of-scan settle after load
                if (st.drop)
                    state_next = pfc_pkg::ST_COUNT;
                else if (st.scan_end)
                    state_next = pfc_pkg::ST_INSERT;
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = pfc_pkg::ST_CMP;
                end
            end
            pfc_pkg::ST_CMP:
            begin
                if (st.match)
                    state_next = pfc_pkg::ST_COUNT;
                else
                begin
                    cmd.cnt_step = 1'b1;
                    state_next = pfc_pkg::ST_READ;
                end
            end
            pfc_pkg::ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = pfc_pkg::ST_COUNT;
            end
            pfc_pkg::ST_COUNT:
            begin
                cmd.count = 1'b1;
                state_next = pfc_pkg::ST_OUT;
            end
            pfc_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = pfc_pkg::ST_IDLE;
            end
            default: state_next = pfc_pkg::ST_IDLE;
        endcase
    end

    property p_ready_idle;
        @(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready during output");

    property p_insert_then_count;
        @(posedge clk) disable iff (!rst_n) cmd.insert |=> cmd.count;
    endproperty
    a_insert_then_count: assert property (p_insert_then_count) else $error("insert w/o count");

    property p_load_goes_read;
        @(posedge clk) disable iff (!rst_n) cmd.load |=> state_reg == pfc_pkg::ST_READ;
    endproperty
    a_load_goes_read: assert property (p_load_goes_read) else $error("load did not start scan");

endmodule

// ===== hdl/pfc_datapath.sv =====
// Header decode, flow table memory, scan compare and counters.
module pfc_datapath
#(
    parameter int FLOW_ENTRIES = 256,
    parameter int COUNTER_BITS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pfc_pkg::IN_BITS-1:0]   in_item,
    input  pfc_pkg::cmd_t                 cmd,
    output pfc_pkg::status_t              st,
    output logic [pfc_pkg::OUT_BITS-1:0]  out_item
);

    localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int FW = $clog2(FLOW_ENTRIES + 1);
    localparam int KB = pfc_pkg::KEY_BITS;

    logic [KB-1:0] mem [FLOW_ENTRIES];
    logic [KB-1:0] rd_data_reg;
    logic [KB-1:0] key_reg;
    logic          tcp_reg, drop_reg, newf_reg, full_reg;
    logic [5:0]    l4_reg;
    logic [15:0]   pay_reg;
    logic [FW-1:0] idx_reg, fill_reg, tcp_fill_reg;
    logic [COUNTER_BITS-1:0] pkt_reg, tcp_pkt_reg, udp_pkt_reg, tcp_by_reg, udp_by_reg;

    // decode of the incoming beat
    logic [15:0] etype, sport, dport, caplen;
    logic [7:0]  vih, p4, p6, proto;
    logic [63:0] sh, sl, dh, dl;
    logic [3:0]  doff;
    logic        is_v4, is_v6, eth_ok, is_tcp, drop;
    logic [5:0]  l4;
    logic [17:0] used;

    assign etype  = in_item[15:0];
    assign vih    = in_item[23:16];
    assign p4     = in_item[31:24];
    assign p6     = in_item[39:32];
    assign sh     = in_item[103:40];
    assign sl     = in_item[167:104];
    assign dh     = in_item[231:168];
    assign dl     = in_item[295:232];
    assign sport  = in_item[311:296];
    assign dport  = in_item[327:312];
    assign doff   = in_item[331:328];
    assign caplen = in_item[347:332];

    assign eth_ok = (etype == pfc_pkg::ETHTYPE_V4) || (etype == pfc_pkg::ETHTYPE_V6);
    assign is_v4  = eth_ok && (vih[7:4] == pfc_pkg::VER_4);
    assign is_v6  = eth_ok && (vih[7:4] == pfc_pkg::VER_6);
    assign proto  = is_v6 ? p6 : p4;
    assign is_tcp = proto == pfc_pkg::PROTO_TCP;
    assign drop   = !(is_v4 || is_v6) || !(is_tcp || proto == pfc_pkg::PROTO_UDP);
    assign l4     = is_tcp ? {doff, 2'b00} : pfc_pkg::UDP_HDR_BYTES;
    assign used   = pfc_pkg::ETH_HDR_BYTES + {12'd0, l4}
                  + (is_v6 ? pfc_pkg::V6_HDR_BYTES : {12'd0, vih[3:0], 2'b00});

    logic [15:0] cap_m;
    assign cap_m = caplen - used[15:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= {is_v6, is_tcp, dport, sport,
                        is_v6 ? dh : 64'd0, is_v6 ? dl : {32'd0, dl[31:0]},
                        is_v6 ? sh : 64'd0, is_v6 ? sl : {32'd0, sl[31:0]}};
            tcp_reg <= is_tcp;
            l4_reg  <= drop ? 6'd0 : l4;
            pay_reg <= (drop || ({2'b00, caplen} <= used)) ? 16'd0 : cap_m;
        end
        if (cmd.rd)
            rd_data_reg <= mem[idx_reg[IW-1:0]];
        if (cmd.insert && !full_reg)
            mem[fill_reg[IW-1:0]] <= key_reg;
    end

    logic [COUNTER_BITS-1:0] add_by;
    assign add_by = COUNTER_BITS'({l4_reg}) + COUNTER_BITS'(pay_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg <= 1'b0; newf_reg <= 1'b0; full_reg <= 1'b0;
            idx_reg <= '0; fill_reg <= '0; tcp_fill_reg <= '0;
            pkt_reg <= '0; tcp_pkt_reg <= '0; udp_pkt_reg <= '0;
            tcp_by_reg <= '0; udp_by_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                drop_reg <= drop;
                newf_reg <= 1'b0;
                full_reg <= fill_reg == FW'(FLOW_ENTRIES);
                idx_reg  <= '0;
            end
            if (cmd.cnt_step)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.insert)
            begin
                if (!full_reg)
                begin
                    newf_reg <= 1'b1;
                    fill_reg <= fill_reg + 1'b1;
                    if (tcp_reg)
                        tcp_fill_reg <= tcp_fill_reg + 1'b1;
                end
            end
            else if (cmd.count)
                full_reg <= 1'b0;
            if (cmd.count)
            begin
                pkt_reg <= pkt_reg + 1'b1;
                if (!drop_reg && tcp_reg)
                begin
                    tcp_pkt_reg <= tcp_pkt_reg + 1'b1;
                    tcp_by_reg  <= tcp_by_reg + add_by;
                end
                else if (!drop_reg)
                begin
                    udp_pkt_reg <= udp_pkt_reg + 1'b1;
                    udp_by_reg  <= udp_by_reg + add_by;
                end
            end
        end
    end

    // full flag kept only when the insert path was taken
    logic full_out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_out_reg <= 1'b0;
        else if (cmd.load)
            full_out_reg <= 1'b0;
        else if (cmd.insert)
            full_out_reg <= full_reg;
    end

    assign st.drop     = drop_reg;
    assign st.match    = rd_data_reg == key_reg;
    assign st.scan_end = idx_reg == fill_reg;

    logic [1:0] cls;
    assign cls = drop_reg ? pfc_pkg::CLASS_DROP
               : (tcp_reg ? pfc_pkg::CLASS_TCP : pfc_pkg::CLASS_UDP);

    function automatic logic [31:0] lo32(input logic [COUNTER_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    assign out_item = {lo32(udp_by_reg), lo32(tcp_by_reg), lo32(udp_pkt_reg),
                       lo32(tcp_pkt_reg), lo32(pkt_reg),
                       32'(tcp_fill_reg), 32'(fill_reg),
                       full_out_reg, newf_reg, pay_reg, l4_reg, cls};

    property p_fill_bound;
        @(posedge clk) disable iff (!rst_n) fill_reg <= FW'(FLOW_ENTRIES);
    endproperty
    a_fill_bound: assert property (p_fill_bound) else $error("fill overflow");

    property p_tcp_le_fill;
        @(posedge clk) disable iff (!rst_n) tcp_fill_reg <= fill_reg;
    endproperty
    a_tcp_le_fill: assert property (p_tcp_le_fill) else $error("tcp fill above fill");

    property p_newf_full;
        @(posedge clk) disable iff (!rst_n) !(newf_reg && full_out_reg);
    endproperty
    a_newf_full: assert property (p_newf_full) else $error("new flow and full");

endmodule

// ===== hdl/packet_flow_classifier_core.sv =====
// Top level of the packet flow classifier.
//
// One slave beat carries the parsed header fields of one captured frame;
// one master beat returns its class, header and payload sizes, flow table
// flags and the running totals after that frame.
// A frame is classified as TCP, UDP or dropped; accepted frames have their
// five-tuple plus IP version looked up in a FLOW_ENTRIES deep table and
// inserted at the fill point when new and the table is not full.
// Each stored entry compared costs a registered memory read then a compare,
// so the scan over the table memory sets the latency; dropped frames skip
// the scan and go straight to counting.
// One frame is in the block at a time: s_tready is high only while idle,
// so the next beat is taken at the earliest in the cycle after delivery.
// The result waits in the output register while m_tready is low; no new
// beat is taken until it is delivered.
// Reset empties the table (fill count to zero) and clears every counter at
// once; no clearing pass is needed as entries above the fill count are never
// read.
module packet_flow_classifier_core
#(
    parameter int FLOW_ENTRIES = 256,
    parameter int COUNTER_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // eth_type, version_ihl, ipv4_protocol, ipv6_next_header,
    // source_addr_high, source_addr_low, dest_addr_high, dest_addr_low,
    // source_port, dest_port, tcp_data_offset, captured_length, zero pad
    input  logic [pfc_pkg::IN_BITS-1:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // packet_class, l4_header_bytes, payload_bytes, new_flow, flow_table_full,
    // flows_seen, tcp_flows_seen, packets_seen, tcp_packets_seen,
    // udp_packets_seen, tcp_bytes_seen, udp_bytes_seen, zero pad
    output logic [255:0] m_tdata
);

    pfc_pkg::cmd_t    cmd;
    pfc_pkg::status_t st;
    logic [pfc_pkg::OUT_BITS-1:0] res;

    pfc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .st        (st),
        .cmd       (cmd)
    );

    pfc_datapath #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .out_item (res)
    );

    assign m_tdata = {6'd0, res};

endmodule
